// ----- src/complex_rect_polar_converter_assert.svh -----
// Assertion macros for the rectangular/polar converter checker
`ifndef COMPLEX_RECT_POLAR_CONVERTER_ASSERT_SVH
`define COMPLEX_RECT_POLAR_CONVERTER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CRPC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CRPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/crpc_pkg.sv -----
package crpc_pkg;

	localparam int ROTATION_STEPS_DEF = 24;
	localparam int FRACTION_BITS_DEF  = 16;
	localparam int GUARD              = 8;
	// 32-bit value scaled by 2^GUARD, plus growth headroom
	localparam int XW                 = 44;
	localparam logic [31:0] INV_GAIN  = 32'h4DBA76D4;

	typedef struct packed {
		logic        is_polar;
		logic signed [31:0] first_value;
		logic signed [31:0] second_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] real_out;
		logic signed [31:0] imag_out;
		logic signed [31:0] magnitude_out;
		logic signed [31:0] angle_out;
	} out_item_t;

	// data carried from cell to cell
	typedef struct packed {
		logic              vld;
		logic              polar;
		logic              zero;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic [31:0]        z;
	} cell_t;

	// arctangent of 2^-i as binary angle
	function automatic logic [31:0] atan_tab(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
				5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
				5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
				5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
				5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
				5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
				5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
				5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
				5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
				5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
				5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
				5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
				5'd30: r = 32'h00000001;
				default: r = 32'h00000000;
			endcase
			return r;
		end
	endfunction

endpackage

// ----- src/crpc_cell.sv -----
// One CORDIC micro-rotation with a register on its output
module crpc_cell #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  crpc_pkg::cell_t d,
	output crpc_pkg::cell_t q
);
	logic signed [crpc_pkg::XW-1:0] dx, dy;
	logic                           rot_pos;
	crpc_pkg::cell_t                nxt;
	logic                           vld_q;
	crpc_pkg::cell_t                stage_q;

	assign dx = d.y >>> STEP;
	assign dy = d.x >>> STEP;

	// rotation mode steers by the angle sign, vectoring by the sign of y
	assign rot_pos = d.polar ? ~d.z[31] : d.y[crpc_pkg::XW-1];

	always_comb begin
		nxt = d;
		if (rot_pos) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - crpc_pkg::atan_tab(5'(STEP));
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + crpc_pkg::atan_tab(5'(STEP));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= nxt;
		end
	end

	// data from the plain register, valid from the reset one
	always_comb begin
		q     = stage_q;
		q.vld = vld_q;
	end
endmodule

// ----- src/crpc_prep.sv -----
// Entry stages: angle reduction to binary angle and quadrant fold
// Stage 1 offsets the angle by whole turns and estimates degrees/360,
// stage 2 forms the reduced angle times 2^(32-F) plus rounding,
// stages 3 to 5 divide that by 360 in two 16-bit digits, then the fold.
module crpc_prep #(
	parameter int FRACTION_BITS = crpc_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  crpc_pkg::in_item_t in_item,
	output crpc_pkg::cell_t    q
);
	localparam longint P360  = 64'sd360 <<< FRACTION_BITS;
	// whole turns added so any 32-bit angle becomes non-negative
	localparam longint TURNS = ((64'sd1 <<< 31) + P360 - 64'sd1) / P360;
	localparam longint OFS   = TURNS * P360;
	// reciprocal of 360 scaled by 2^34, exact for dividends below 2^25
	localparam logic [25:0] RECIP = 26'(((64'd1 << 34) + 64'd359) / 64'd360);

	logic [32:0]                    um;
	logic [24:0]                    vm_in;
	logic [16:0]                    qm;
	logic                           vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_q;
	crpc_pkg::in_item_t             it_s1, it_s2, it_s3, it_s4, it_s5;
	logic [32:0]                    um_s1;
	logic [16:0]                    qm_s1;
	logic [24:0]                    vm;
	logic [8:0]                     hf;
	logic [40:0]                    t;
	logic [40:0]                    t_s2;
	logic [15:0]                    q1;
	logic [15:0]                    q1_s3, tl_s3;
	logic [24:0]                    th_s3;
	logic [8:0]                     rh;
	logic [15:0]                    q1_s4;
	logic [24:0]                    d2_s4;
	logic [15:0]                    q2;
	logic [31:0]                    zbin_s5;
	logic signed [crpc_pkg::XW-1:0] xa, yb;
	crpc_pkg::cell_t                nxt, stage_q;

	// stage 1: non-negative angle, whole-degree part over 360
	always_comb begin
		um    = 33'(longint'(in_item.second_value) + OFS);
		vm_in = 25'(um >> FRACTION_BITS);
		qm    = 17'((51'(vm_in) * 51'(RECIP)) >> 34);
	end

	// stage 2: degrees mod 360, scaled to a 2^32 turn, plus half of 360
	always_comb begin
		vm = 25'(um_s1 >> FRACTION_BITS);
		hf = 9'(vm - 25'(qm_s1) * 25'd360);
		t  = (41'(hf) << 32) + (41'(um_s1[FRACTION_BITS-1:0]) << (32 - FRACTION_BITS))
			+ 41'd180;
	end

	// stage 3: upper quotient digit
	assign q1 = 16'((51'(t_s2[40:16]) * 51'(RECIP)) >> 34);

	// stage 4: upper digit remainder
	assign rh = 9'(th_s3 - 25'(q1_s3) * 25'd360);

	// stage 5: lower quotient digit
	assign q2 = 16'((51'(d2_s4) * 51'(RECIP)) >> 34);

	// fold into the right half plane and scale the operands
	always_comb begin
		xa        = crpc_pkg::XW'(it_s5.first_value) <<< crpc_pkg::GUARD;
		yb        = crpc_pkg::XW'(it_s5.second_value) <<< crpc_pkg::GUARD;
		nxt.vld   = vld_s5;
		nxt.polar = it_s5.is_polar;
		nxt.zero  = (it_s5.first_value == 32'sd0) && (it_s5.second_value == 32'sd0);
		nxt.a     = it_s5.first_value;
		nxt.b     = it_s5.second_value;
		if (it_s5.is_polar) begin
			nxt.y = '0;
			nxt.x = xa;
			nxt.z = zbin_s5;
			if ((zbin_s5 + 32'h40000000) > 32'h80000000) begin
				nxt.x = -xa;
				nxt.z = zbin_s5 + 32'h80000000;
			end
		end else begin
			nxt.x = xa;
			nxt.y = yb;
			nxt.z = '0;
			if (xa < 0) begin
				nxt.x = -xa;
				nxt.y = -yb;
				nxt.z = 32'h80000000;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_q  <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1   <= in_item;
			um_s1   <= um;
			qm_s1   <= qm;
			it_s2   <= it_s1;
			t_s2    <= t;
			it_s3   <= it_s2;
			q1_s3   <= q1;
			th_s3   <= t_s2[40:16];
			tl_s3   <= t_s2[15:0];
			it_s4   <= it_s3;
			q1_s4   <= q1_s3;
			d2_s4   <= {rh, tl_s3};
			it_s5   <= it_s4;
			zbin_s5 <= {q1_s4, q2};
			stage_q <= nxt;
		end
	end

	// data from the plain register, valid from the reset one
	always_comb begin
		q     = stage_q;
		q.vld = vld_q;
	end
endmodule

// ----- src/crpc_post.sv -----
// Exit stages: gain removal, degree conversion, saturation
module crpc_post #(
	parameter int FRACTION_BITS = crpc_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  crpc_pkg::cell_t    d,
	output logic               q_vld,
	output crpc_pkg::out_item_t q
);
	localparam int SH = 29 - FRACTION_BITS;

	logic [crpc_pkg::XW-1:0] ax, ay;
	logic [31:0]             az;
	logic [63:0]             pxl, pyl;
	logic [43:0]             pxh, pyh;
	logic [63:0]             pz;
	logic                    v_s1, pol_s1, zero_s1, sx_s1, sy_s1, sz_s1;
	logic signed [31:0]      a_s1, b_s1;
	logic [63:0]             pxl_s1, pyl_s1;
	logic [43:0]             pxh_s1, pyh_s1;
	logic [63:0]             pz_s1;

	// stage 1: magnitudes and partial products (low and high word)
	always_comb begin
		ax  = d.x[crpc_pkg::XW-1] ? crpc_pkg::XW'(-d.x) : crpc_pkg::XW'(d.x);
		ay  = d.y[crpc_pkg::XW-1] ? crpc_pkg::XW'(-d.y) : crpc_pkg::XW'(d.y);
		az  = d.z[31] ? (32'd0 - d.z) : d.z;
		pxl = 64'(ax[31:0]) * 64'(crpc_pkg::INV_GAIN);
		pyl = 64'(ay[31:0]) * 64'(crpc_pkg::INV_GAIN);
		pxh = 44'(ax[crpc_pkg::XW-1:32]) * 44'(crpc_pkg::INV_GAIN);
		pyh = 44'(ay[crpc_pkg::XW-1:32]) * 44'(crpc_pkg::INV_GAIN);
		pz  = 64'(az) * 64'd45;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pol_s1  <= d.polar;
			zero_s1 <= d.zero;
			sx_s1   <= d.x[crpc_pkg::XW-1];
			sy_s1   <= d.y[crpc_pkg::XW-1];
			sz_s1   <= d.z[31];
			a_s1    <= d.a;
			b_s1    <= d.b;
			pxl_s1  <= pxl;
			pyl_s1  <= pyl;
			pxh_s1  <= pxh;
			pyh_s1  <= pyh;
			pz_s1   <= pz;
		end
	end

	// saturate a signed value to 32 bits
	function automatic logic [31:0] sat(input logic signed [47:0] v);
		logic [31:0] r;
		begin
			if (v > 48'sd2147483647)
				r = 32'h7FFFFFFF;
			else if (v < -48'sd2147483648)
				r = 32'h80000000;
			else
				r = v[31:0];
			return r;
		end
	endfunction

	// stage 2: rounding, sign, saturation, selection
	logic [47:0] ux, uy, ud;
	logic signed [47:0] vx, vy, vd;
	localparam logic signed [47:0] HALF = 48'sd180 <<< FRACTION_BITS;
	crpc_pkg::out_item_t nxt;
	always_comb begin
		ux = 48'(((76'(pxh_s1) << 32) + 76'(pxl_s1) + (76'd1 << (30 + crpc_pkg::GUARD)))
			>> (31 + crpc_pkg::GUARD));
		uy = 48'(((76'(pyh_s1) << 32) + 76'(pyl_s1) + (76'd1 << (30 + crpc_pkg::GUARD)))
			>> (31 + crpc_pkg::GUARD));
		ud = 48'((pz_s1 + (64'd1 << (SH - 1))) >> SH);
		vx = sx_s1 ? -$signed(ux) : $signed(ux);
		vy = sy_s1 ? -$signed(uy) : $signed(uy);
		vd = sz_s1 ? -$signed(ud) : $signed(ud);
		if (vd <= -HALF)
			vd = HALF;
		if (pol_s1) begin
			nxt.real_out      = sat(vx);
			nxt.imag_out      = sat(vy);
			nxt.magnitude_out = a_s1;
			nxt.angle_out     = b_s1;
		end else if (zero_s1) begin
			nxt = '0;
		end else begin
			nxt.real_out      = a_s1;
			nxt.imag_out      = b_s1;
			nxt.magnitude_out = sat(vx);
			nxt.angle_out     = sat(vd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_vld <= 1'b0;
		end else if (en) begin
			q_vld <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// ----- src/complex_rect_polar_converter.sv -----
// Rectangular/polar complex converter, unrolled CORDIC pipeline.
// Stages from input transfer to result valid (steps capped at 32): six
// entry stages, one per rotation step, two exit stages.
// Throughput: one item per cycle; the whole chain stalls only when the
// output is full and not taken (ready = !out_valid || out_ready).
// Reset: arst_n clears all valid flags asynchronously; data is not reset.
module complex_rect_polar_converter #(
	parameter int ROTATION_STEPS = crpc_pkg::ROTATION_STEPS_DEF,
	parameter int FRACTION_BITS  = crpc_pkg::FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  crpc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output crpc_pkg::out_item_t out_data
);
	localparam int N = (ROTATION_STEPS > 32) ? 32 : ROTATION_STEPS;

	logic            en;
	crpc_pkg::cell_t chain [N+1];

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	crpc_prep #(.FRACTION_BITS(FRACTION_BITS)) u_prep (
		.clk, .arst_n, .en,
		.in_vld(in_valid), .in_item(in_data), .q(chain[0])
	);

	// row of rotation cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		crpc_cell #(.STEP(i)) u_cell (
			.clk, .arst_n, .en, .d(chain[i]), .q(chain[i+1])
		);
	end

	crpc_post #(.FRACTION_BITS(FRACTION_BITS)) u_post (
		.clk, .arst_n, .en, .d(chain[N]), .q_vld(out_valid), .q(out_data)
	);
endmodule

// ----- src/crpc_checker.sv -----
`include "complex_rect_polar_converter_assert.svh"

// Port-level checks on the converter
module crpc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input crpc_pkg::out_item_t out_data
);
	`CRPC_ASSERT(a_ready_free, !out_valid, in_ready, "input stalled with output empty")
	`CRPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
	`CRPC_ASSERT(a_ready_link, out_valid && out_ready, in_ready, "input stalled while output taken")
endmodule

bind complex_rect_polar_converter crpc_checker u_crpc_checker (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .out_data
);
